### design/pipt_pkg.sv
// shared types and constants for the point in polygon tester
// no dependencies; used by pipt_edge and point_in_polygon_test_core
`timescale 1ns / 1ps
`default_nettype none

package pipt_pkg;

  localparam int unsigned MAX_VERTICES      = 16;
  localparam int unsigned COORD_WIDTH       = 16;
  localparam int unsigned MIN_POLY_VERTICES = 3;

  // item kind codes
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  // status of the edge pipeline towards the sequencer
  typedef struct packed {
    logic busy;
    logic toggle;
  } edge_status_t;

endpackage

`default_nettype wire

### design/point_in_polygon_test_core.sv
// top level of the even-odd point in polygon tester with its vertex tables
// depends on pipt_pkg and pipt_edge
//
// channel   direction  ports                                            beat taken when
// item      in         start, kind_i, vertex_index_i, coord_x_i/y_i     start && !busy
// result    out        done_o, inside_res_o, degenerate_o               done_o (one cycle)
// config    in         cfg_valid_i, cfg_ready_o, cfg_data_i             cfg_valid_i && cfg_ready_o
//
// a query with fewer than three vertices gives its result in the cycle after
// acceptance and keeps busy low; any other query holds busy while the single
// table read port makes count + 1 reads and the drain then waits for crossings
// still in the stages; the result comes in the same cycle that busy drops and
// cannot be stalled
// reset clears the vertex count and control; the tables are not cleared
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_core #(
  parameter int unsigned MAX_VERTICES = pipt_pkg::MAX_VERTICES,
  parameter int unsigned COORD_WIDTH  = pipt_pkg::COORD_WIDTH,
  localparam int unsigned IDX_W = $clog2(MAX_VERTICES),
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start,
  output logic                               busy,
  input  wire                                kind_i,
  input  wire        [IDX_W-1:0]             vertex_index_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y_i,
  output logic                               done_o,
  output logic                               inside_res_o,
  output logic                               degenerate_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire        [CNT_W-1:0]             cfg_data_i
);

  pipt_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_sat;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] iss_q;
  logic [IDX_W-1:0] rd_addr;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] rd_x_q, rd_y_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q;

  logic rd_vld_q, rd_first_q;
  logic inside_q;
  logic done_q, res_inside_q, res_degen_q;

  logic accept, accept_query, accept_write, degen, slot_ok;
  logic busy_w, issue_en, finish, last_iss, pipe_empty;

  pipt_pkg::edge_status_t edge_sts;

  assign accept       = start && !busy_w;
  assign accept_query = accept && (kind_i == pipt_pkg::KIND_QUERY);
  assign accept_write = accept && (kind_i == pipt_pkg::KIND_VERTEX);
  assign slot_ok      = {1'b0, vertex_index_i} < (IDX_W + 1)'(MAX_VERTICES);
  assign count_sat    = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;
  assign degen        = count_sat < CNT_W'(pipt_pkg::MIN_POLY_VERTICES);
  assign last_iss     = iss_q == cnt_q;
  assign rd_addr      = (iss_q == '0) ? IDX_W'(cnt_q - 1'b1) : IDX_W'(iss_q - 1'b1);
  assign pipe_empty   = !rd_vld_q && !edge_sts.busy;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pipt_pkg::ST_IDLE: begin
        if (accept_query && !degen) state_d = pipt_pkg::ST_WALK;
      end
      pipt_pkg::ST_WALK: begin
        if (last_iss) state_d = pipt_pkg::ST_DRAIN;
      end
      pipt_pkg::ST_DRAIN: begin
        if (pipe_empty) state_d = pipt_pkg::ST_IDLE;
      end
      default: state_d = pipt_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_w   = 1'b1;
    issue_en = 1'b0;
    finish   = 1'b0;
    unique case (state_q)
      pipt_pkg::ST_IDLE:  busy_w = 1'b0;
      pipt_pkg::ST_WALK:  issue_en = 1'b1;
      pipt_pkg::ST_DRAIN: finish = pipe_empty;
      default:            busy_w = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pipt_pkg::ST_IDLE;
      count_q      <= '0;
      cnt_q        <= '0;
      iss_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_first_q   <= 1'b0;
      inside_q     <= 1'b0;
      done_q       <= 1'b0;
      res_inside_q <= 1'b0;
      res_degen_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue_en;
      rd_first_q <= issue_en && (iss_q == '0);
      done_q     <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) count_q <= cfg_data_i;
      if (accept_query) begin
        cnt_q    <= count_sat;
        iss_q    <= '0;
        inside_q <= 1'b0;
        if (degen) begin
          done_q       <= 1'b1;
          res_inside_q <= 1'b0;
          res_degen_q  <= 1'b1;
        end
      end
      if (issue_en) iss_q <= iss_q + 1'b1;
      if (edge_sts.toggle) inside_q <= !inside_q;
      if (finish) begin
        done_q       <= 1'b1;
        res_inside_q <= inside_q;
        res_degen_q  <= 1'b0;
      end
    end
  end

  // query point, payload only
  always_ff @(posedge clk_i) begin
    if (accept_query) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
  end

  // vertex tables
  always_ff @(posedge clk_i) begin
    if (accept_write && slot_ok) begin
      mem_x[vertex_index_i] <= coord_x_i;
      mem_y[vertex_index_i] <= coord_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_en) begin
      rd_x_q <= mem_x[rd_addr];
      rd_y_q <= mem_y[rd_addr];
    end
  end

  pipt_edge #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .first_i(rd_first_q),
    .vx_i   (rd_x_q),
    .vy_i   (rd_y_q),
    .px_i   (px_q),
    .py_i   (py_q),
    .sts_o  (edge_sts)
  );

  assign busy         = busy_w;
  assign cfg_ready_o  = !busy_w;
  assign done_o       = done_q;
  assign inside_res_o = res_inside_q;
  assign degenerate_o = res_degen_q;

endmodule

`default_nettype wire

### design/pipt_edge.sv
// edge crossing pipeline: pairs each vertex read with the previous one and
// decides by an exact cross-multiplied compare whether the ray crosses it
// depends on pipt_pkg
`timescale 1ns / 1ps
`default_nettype none

module pipt_edge #(
  parameter int unsigned COORD_WIDTH = pipt_pkg::COORD_WIDTH
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           vld_i,
  input  wire                           first_i,
  input  wire logic signed [COORD_WIDTH-1:0] vx_i,
  input  wire logic signed [COORD_WIDTH-1:0] vy_i,
  input  wire logic signed [COORD_WIDTH-1:0] px_i,
  input  wire logic signed [COORD_WIDTH-1:0] py_i,
  output pipt_pkg::edge_status_t        sts_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;

  logic signed [DW-1:0] a_d, b_d, c_d, d_d;
  logic signed [DW-1:0] a_q, b_q, c_q, d_q;
  logic                 gate_d;
  logic                 e_vld_q;

  logic signed [PW-1:0] p1_d, p2_d, p1_q, p2_q;
  logic                 dneg_q;
  logic                 m_vld_q;

  logic                 flip;

  // stage one: differences and straddle test
  always_comb begin
    a_d = DW'(py_i) - DW'(vy_i);
    b_d = DW'(prev_x_q) - DW'(vx_i);
    c_d = DW'(px_i) - DW'(vx_i);
    d_d = DW'(prev_y_q) - DW'(vy_i);
    gate_d = ((vy_i < py_i && prev_y_q >= py_i) || (prev_y_q < py_i && vy_i >= py_i)) &&
             (vx_i <= px_i || prev_x_q <= px_i);
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      prev_x_q <= vx_i;
      prev_y_q <= vy_i;
    end
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
  end

  // stage two: the two products
  always_comb begin
    p1_d = a_q * b_q;
    p2_d = c_q * d_q;
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    dneg_q <= d_q < 0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
    end else begin
      e_vld_q <= vld_i && !first_i && gate_d;
      m_vld_q <= e_vld_q;
    end
  end

  // stage three: compare, sense flipped by edge direction
  always_comb begin
    flip = m_vld_q && (dneg_q ? (p1_q > p2_q) : (p1_q < p2_q));
  end

  assign sts_o.busy   = e_vld_q | m_vld_q;
  assign sts_o.toggle = flip;

endmodule

`default_nettype wire

### sim/tb_point_in_polygon_test_core.sv
// self-checking testbench for point_in_polygon_test_core: vertex writes and queries
// are predicted with an exact even-odd edge walk kept in the bench; needs pipt_pkg
// and the design sources, nothing else
`timescale 1ns / 1ps

module tb_point_in_polygon_test_core;

  localparam int unsigned SETTLE_CYCLES = pipt_pkg::MAX_VERTICES + 8;
  localparam int unsigned ITEM_TARGET   = 550;
  localparam int unsigned MODE_WIDE     = 0;
  localparam int unsigned MODE_GRID     = 1;
  localparam int unsigned MODE_EXTREME  = 2;
  localparam int unsigned MODE_HUG      = 3;

  typedef struct packed {
    logic in_poly;
    logic degenerate;
  } verdict_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    kind_i;
  logic [3:0]              vertex_index_i;
  logic signed [15:0]      coord_x_i;
  logic signed [15:0]      coord_y_i;
  logic                    done_o;
  logic                    inside_res_o;
  logic                    degenerate_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [4:0]              cfg_data_i;

  logic signed [15:0]      poly_x [pipt_pkg::MAX_VERTICES];
  logic signed [15:0]      poly_y [pipt_pkg::MAX_VERTICES];
  logic [4:0]              shadow_count;
  verdict_t                expected_verdicts [$];

  bit                      no_gaps;
  int unsigned             error_count;
  int unsigned             n_items;
  int unsigned             n_writes;
  int unsigned             n_queries;
  int unsigned             n_checked;
  int unsigned             n_inside;
  int unsigned             n_count_writes;
  int unsigned             n_phases;

  point_in_polygon_test_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .vertex_index_i (vertex_index_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .done_o         (done_o),
    .inside_res_o   (inside_res_o),
    .degenerate_o   (degenerate_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("FAIL");
    $finish;
  end

  // exact crossing test: products of 17-bit differences fit easily in 64 bits
  function automatic verdict_t predict_verdict(input logic signed [15:0] px,
                                               input logic signed [15:0] py);
    verdict_t    v;
    int unsigned n;
    int unsigned j;
    longint      qx, qy, xi, yi, xj, yj, dy, lhs, rhs;
    v.in_poly    = 1'b0;
    v.degenerate = 1'b0;
    n = (shadow_count > pipt_pkg::MAX_VERTICES) ? pipt_pkg::MAX_VERTICES : shadow_count;
    if (n < pipt_pkg::MIN_POLY_VERTICES) begin
      v.degenerate = 1'b1;
      return v;
    end
    qx = px;
    qy = py;
    j  = n - 1;
    for (int unsigned i = 0; i < n; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if (((yi < qy && yj >= qy) || (yj < qy && yi >= qy)) && (xi <= qx || xj <= qx)) begin
        dy  = yj - yi;
        lhs = (qy - yi) * (xj - xi);
        rhs = (qx - xi) * dy;
        if ((dy > 0 && lhs < rhs) || (dy < 0 && lhs > rhs)) v.in_poly = ~v.in_poly;
      end
      j = i;
    end
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned g;
    g = 0;
    if (!no_gaps) begin
      while ($urandom_range(99) < 31) g++;
    end
    return g;
  endfunction

  function automatic logic signed [15:0] pick_coord(input int unsigned mode);
    int v;
    v = $urandom;
    if (mode == MODE_GRID) begin
      v = int'($urandom_range(12)) - 6;
    end else if (mode == MODE_EXTREME) begin
      case ($urandom_range(4))
        0: v = -32768;
        1: v = -1;
        2: v = 0;
        3: v = 1;
        default: v = 32767;
      endcase
    end
    return v[15:0];
  endfunction

  task automatic send_item(input logic kind, input logic [3:0] slot,
                           input logic signed [15:0] x, input logic signed [15:0] y);
    int unsigned gap;
    verdict_t    want;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    kind_i         <= kind;
    vertex_index_i <= slot;
    coord_x_i      <= x;
    coord_y_i      <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_items++;
    if (kind == pipt_pkg::KIND_QUERY) begin
      want = predict_verdict(x, y);
      expected_verdicts = {expected_verdicts, want};
      n_queries++;
    end else begin
      poly_x[slot] = x;
      poly_y[slot] = y;
      n_writes++;
    end
  endtask

  // register beats only go out with nothing in flight
  task automatic write_vertex_count(input logic [4:0] value);
    int unsigned gap;
    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    gap = pick_gap();
    repeat (gap) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    shadow_count = value;
    n_count_writes++;
  endtask

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat inside=%0b degenerate=%0b",
                 $time, inside_res_o, degenerate_o);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        n_checked++;
        if (want.in_poly) n_inside++;
        if (inside_res_o !== want.in_poly) begin
          $display("%0t: inside mismatch expected %0b actual %0b",
                   $time, want.in_poly, inside_res_o);
          error_count++;
        end
        if (degenerate_o !== want.degenerate) begin
          $display("%0t: degenerate mismatch expected %0b actual %0b",
                   $time, want.degenerate, degenerate_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_degenerate();
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sh7fff, 16'sh8000);
    send_item(pipt_pkg::KIND_QUERY, 4'd15, 16'sh8000, 16'sh7fff);
    write_vertex_count(5'd1);
    send_item(pipt_pkg::KIND_QUERY, 4'd15, 16'sd0, 16'sd0);
    write_vertex_count(5'd2);
    send_item(pipt_pkg::KIND_QUERY, 4'd7, -16'sd1, 16'sd1);
  endtask

  task automatic test_extreme_polygons();
    send_item(pipt_pkg::KIND_VERTEX, 4'd0, 16'sh8000, 16'sh8000);
    send_item(pipt_pkg::KIND_VERTEX, 4'd1, 16'sh7fff, 16'sh8000);
    send_item(pipt_pkg::KIND_VERTEX, 4'd2, 16'sh7fff, 16'sh7fff);
    send_item(pipt_pkg::KIND_VERTEX, 4'd3, 16'sh8000, 16'sh7fff);
    write_vertex_count(5'd4);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sd0, 16'sd0);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sh8000, 16'sh8000);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sh7fff, 16'sd0);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sd0, 16'sh7fff);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sh8000, 16'sd5);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sh7fff, 16'sh7fff);
    write_vertex_count(5'd3);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sd100, 16'sd0);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, -16'sd100, 16'sd0);
    write_vertex_count(5'd0);
    send_item(pipt_pkg::KIND_QUERY, 4'd0, 16'sd100, 16'sd0);
  endtask

  task automatic pick_query(input int unsigned mode,
                            output logic signed [15:0] x, output logic signed [15:0] y);
    int unsigned k;
    int unsigned m;
    logic signed [16:0] sx;
    logic signed [16:0] sy;
    x = pick_coord(mode);
    y = pick_coord(mode);
    if (mode == MODE_HUG) begin
      k = $urandom_range(pipt_pkg::MAX_VERTICES - 1);
      m = (k == 0) ? pipt_pkg::MAX_VERTICES - 1 : k - 1;
      case ($urandom_range(2))
        0: begin
          x = poly_x[k];
          y = poly_y[k];
        end
        1: begin
          x = poly_x[k];
          y = poly_y[k] + 16'(int'($urandom_range(4)) - 2);
        end
        default: begin
          sx = 17'(poly_x[k]) + 17'(poly_x[m]);
          sy = 17'(poly_y[k]) + 17'(poly_y[m]);
          x  = sx[16:1];
          y  = sy[16:1];
        end
      endcase
    end
  endtask

  task automatic test_random_polygons();
    int unsigned p;
    int unsigned mode;
    int unsigned span;
    int unsigned offs;
    int unsigned nq;
    int unsigned r;
    logic [4:0]         cnt;
    logic signed [15:0] x;
    logic signed [15:0] y;
    p = 0;
    while (n_items < ITEM_TARGET) begin
      mode = $urandom_range(3);
      r    = $urandom_range(9);
      if (p == 0) cnt = 5'd31;
      else if (p == 1) cnt = 5'd16;
      else if (p == 2) cnt = 5'd17;
      else if (r == 0) cnt = 5'($urandom_range(2));
      else if (r == 1) cnt = 5'($urandom_range(31, 17));
      else cnt = 5'($urandom_range(16, 3));
      no_gaps = (p == 3);
      write_vertex_count(cnt);
      span = (cnt > pipt_pkg::MAX_VERTICES) ? pipt_pkg::MAX_VERTICES : cnt;
      offs = $urandom_range(pipt_pkg::MAX_VERTICES - 1);
      for (int unsigned k = 0; k < pipt_pkg::MAX_VERTICES; k++) begin
        if (p == 0 || (k < span && $urandom_range(9) < 6)) begin
          send_item(pipt_pkg::KIND_VERTEX, 4'((k + offs) % pipt_pkg::MAX_VERTICES),
                    pick_coord(mode == MODE_HUG ? MODE_WIDE : mode),
                    pick_coord(mode == MODE_HUG ? MODE_WIDE : mode));
        end
      end
      nq = $urandom_range(50, 30);
      for (int unsigned q = 0; q < nq; q++) begin
        if ($urandom_range(9) == 0) begin
          send_item(pipt_pkg::KIND_VERTEX, 4'($urandom), pick_coord(MODE_WIDE),
                    pick_coord(MODE_WIDE));
        end else begin
          pick_query(mode, x, y);
          send_item(pipt_pkg::KIND_QUERY, 4'($urandom), x, y);
        end
      end
      p++;
    end
    no_gaps  = 1'b0;
    n_phases = p;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    kind_i         = pipt_pkg::KIND_VERTEX;
    vertex_index_i = '0;
    coord_x_i      = '0;
    coord_y_i      = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    shadow_count   = '0;
    no_gaps        = 1'b0;
    error_count    = 0;
    n_items        = 0;
    n_writes       = 0;
    n_queries      = 0;
    n_checked      = 0;
    n_inside       = 0;
    n_count_writes = 0;
    n_phases       = 0;
    for (int k = 0; k < pipt_pkg::MAX_VERTICES; k++) begin
      poly_x[k] = '0;
      poly_y[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_degenerate();
    test_extreme_polygons();
    test_random_polygons();

    start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("%0d items sent: %0d vertex beats, %0d queries, %0d results checked (%0d inside)",
             n_items, n_writes, n_queries, n_checked, n_inside);
    $display("%0d vertex count settings over %0d random polygon phases",
             n_count_writes, n_phases);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
